>>> hw/rtl/ppcd_pkg.sv
// Package for the plane crossing detector: field widths, fixed-point constants,
// register indexes and the word structs shared between the modules.
// Depends on nothing.
`timescale 1ns / 1ps

package ppcd_pkg;

  localparam int unsigned POS_W      = 48;
  localparam int unsigned MOM_W      = 32;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned TSTEP_W    = 32;
  localparam int unsigned FRAC_W     = 24;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TSTEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd2;

  localparam logic [TSTEP_W-1:0] TSTEP_RESET = 32'd1000;

  // speed of light in 2^-24 m per fs, scaled by 2^24
  localparam int unsigned   C_W   = 27;
  localparam logic [C_W-1:0] C_Q24 = 27'd84384075;

  localparam int unsigned LEN_W    = C_W + TSTEP_W;      // c * dt
  localparam int unsigned SQ_W     = 2 * MOM_W;          // |p|^2 + 1
  localparam int unsigned ROOT_W   = SQ_W / 2;           // gamma
  localparam int unsigned GDIV_W   = ROOT_W + FRAC_W;    // gamma * 2^24
  localparam int unsigned DIST_W   = 36;                 // step and gap magnitudes
  localparam int unsigned STEP_NW  = LEN_W + MOM_W;      // c * dt * |p|
  localparam int unsigned INTERP_NW = 2 * DIST_W;        // gap * |d|

  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * FRAC_W);

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic signed [POS_W-1:0] z_pos;
    logic signed [MOM_W-1:0] mom_x;
    logic signed [MOM_W-1:0] mom_y;
    logic signed [MOM_W-1:0] mom_z;
    logic [ID_W-1:0]         particle_id;
    logic [TIME_W-1:0]       now_fs;
  } item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] hit_x;
    logic signed [POS_W-1:0] hit_y;
    logic signed [MOM_W-1:0] out_mom_x;
    logic signed [MOM_W-1:0] out_mom_y;
    logic signed [MOM_W-1:0] out_mom_z;
    logic [ID_W-1:0]         out_id;
    logic [TIME_W-1:0]       hit_time_fs;
  } result_t;

  typedef struct packed {
    logic signed [POS_W-1:0] plane_position;
    logic [TSTEP_W-1:0]      time_step_fs;
    logic                    enable;
  } cfg_t;

  // a particle that crosses the plane, as handed from front to back
  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic signed [MOM_W-1:0] mom_x;
    logic signed [MOM_W-1:0] mom_y;
    logic signed [MOM_W-1:0] mom_z;
    logic [ID_W-1:0]         particle_id;
    logic [TIME_W-1:0]       now_fs;
    logic [DIST_W-1:0]       dx_mag;
    logic [DIST_W-1:0]       dy_mag;
    logic [DIST_W-1:0]       dz_mag;
    logic [DIST_W-1:0]       gap;
  } cross_t;

endpackage

>>> hw/rtl/ppcd_div.sv
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// The caller guarantees num < den * 2^QW. Depends on nothing.
`timescale 1ns / 1ps

module ppcd_div #(
  parameter int unsigned NW = 72,
  parameter int unsigned DW = 36,
  parameter int unsigned QW = 36
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_in [QW];
  logic [DW-1:0] den_in [QW];
  logic [QW-1:0] lq_in  [QW];
  logic [DW-1:0] rem_q  [QW-1];
  logic [DW-1:0] den_q  [QW-1];
  logic [QW-1:0] lq_q   [QW];

  assign rem_in[0] = DW'(num_i >> QW);
  assign den_in[0] = den_i;
  assign lq_in[0]  = num_i[QW-1:0];

  for (genvar j = 1; j < QW; j++) begin : g_link
    assign rem_in[j] = rem_q[j-1];
    assign den_in[j] = den_q[j-1];
    assign lq_in[j]  = lq_q[j-1];
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DW:0] trial;
    logic        take;

    assign trial = {rem_in[j], lq_in[j][QW-1]};
    assign take  = trial >= {1'b0, den_in[j]};

    // low bits shift out as numerator digits, quotient bits shift in
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lq_q[j] <= {lq_in[j][QW-2:0], take};
      end
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= take ? DW'(trial - {1'b0, den_in[j]}) : trial[DW-1:0];
          den_q[j] <= den_in[j];
        end
      end
    end
  end

  assign quo_o = lq_q[QW-1];

endmodule

>>> hw/rtl/ppcd_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on ppcd_pkg.
`timescale 1ns / 1ps

module ppcd_isqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ppcd_pkg::SQ_W-1:0]   rad_i,
  output logic [ppcd_pkg::ROOT_W-1:0] root_o
);

  localparam int unsigned RW     = ppcd_pkg::SQ_W;
  localparam int unsigned STAGES = ppcd_pkg::ROOT_W;

  logic [RW-1:0] rem_in [STAGES];
  logic [RW-1:0] acc_in [STAGES];
  logic [RW-1:0] rem_q  [STAGES-1];
  logic [RW-1:0] acc_q  [STAGES];

  assign rem_in[0] = rad_i;
  assign acc_in[0] = '0;

  for (genvar j = 1; j < STAGES; j++) begin : g_link
    assign rem_in[j] = rem_q[j-1];
    assign acc_in[j] = acc_q[j-1];
  end

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * j);
    logic [RW-1:0] trial;
    logic          take;

    assign trial = acc_in[j] + BIT;
    assign take  = rem_in[j] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[j] <= take ? (acc_in[j] >> 1) + BIT : acc_in[j] >> 1;
      end
    end

    if (j < STAGES - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= take ? rem_in[j] - trial : rem_in[j];
        end
      end
    end
  end

  assign root_o = acc_q[STAGES-1][STAGES-1:0];

endmodule

>>> hw/rtl/ppcd_front.sv
// Front end: takes particles, works out gamma and the step, keeps only plane crossings.
// Depends on ppcd_pkg, ppcd_isqrt and ppcd_div.
`timescale 1ns / 1ps

module ppcd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ppcd_pkg::cfg_t   cfg_i,
  input  logic             start_i,
  input  ppcd_pkg::item_t  item_i,
  input  logic             full_i,
  output logic             busy_o,
  output logic             push_o,
  output ppcd_pkg::cross_t cross_o
);

  localparam int unsigned NAX      = 3;
  localparam int unsigned SQRT_LAT = ppcd_pkg::ROOT_W;
  localparam int unsigned SIDE_LAT = SQRT_LAT + ppcd_pkg::DIST_W;
  localparam int unsigned MW       = ppcd_pkg::MOM_W;
  localparam int unsigned HI_W     = ppcd_pkg::LEN_W - MW;

  function automatic logic [MW-1:0] mag_of(input logic signed [MW-1:0] v);
    return v[MW-1] ? MW'(-v) : MW'(v);
  endfunction

  logic                            adv;
  logic [ppcd_pkg::LEN_W-1:0]      len_q;
  logic                            s1_vld_q, s2_vld_q, s3_vld_q;
  ppcd_pkg::item_t                 s1_q, s2_q, s3_q;
  logic [MW-1:0]                   mag [NAX];
  logic [ppcd_pkg::SQ_W-1:0]       sq_q [NAX];
  logic [2*MW-1:0]                 pl_q [NAX];
  logic [HI_W+MW-1:0]              ph_q [NAX];
  logic [ppcd_pkg::SQ_W-1:0]       rad_q;
  logic [ppcd_pkg::STEP_NW-1:0]    num_q [NAX];
  logic [ppcd_pkg::STEP_NW-1:0]    num_dly_q [SQRT_LAT][NAX];
  logic [ppcd_pkg::ROOT_W-1:0]     root;
  logic [ppcd_pkg::GDIV_W-1:0]     gdiv;
  logic [ppcd_pkg::DIST_W-1:0]     dmag [NAX];
  ppcd_pkg::item_t                 side_q [SIDE_LAT];
  logic [SIDE_LAT-1:0]             vld_q;
  ppcd_pkg::item_t                 tail;
  logic signed [ppcd_pkg::POS_W:0] gap;
  logic                            hit_plane;

  // freeze the particle pipeline while the queue is full
  assign adv    = !full_i;
  assign busy_o = full_i;

  assign mag[0] = mag_of(s1_q.mom_x);
  assign mag[1] = mag_of(s1_q.mom_y);
  assign mag[2] = mag_of(s1_q.mom_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      vld_q    <= '0;
    end else if (adv) begin
      s1_vld_q <= start_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      vld_q    <= {vld_q[SIDE_LAT-2:0], s3_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= ppcd_pkg::LEN_W'(ppcd_pkg::C_Q24) * ppcd_pkg::LEN_W'(cfg_i.time_step_fs);
    if (adv) begin
      s1_q <= item_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
      for (int k = 0; k < NAX; k++) begin
        sq_q[k]  <= ppcd_pkg::SQ_W'(mag[k]) * ppcd_pkg::SQ_W'(mag[k]);
        pl_q[k]  <= (2*MW)'(len_q[MW-1:0]) * (2*MW)'(mag[k]);
        ph_q[k]  <= (HI_W+MW)'(len_q[ppcd_pkg::LEN_W-1:MW]) * (HI_W+MW)'(mag[k]);
        num_q[k] <= (ppcd_pkg::STEP_NW'(ph_q[k]) << MW) + ppcd_pkg::STEP_NW'(pl_q[k]);
      end
      rad_q <= sq_q[0] + sq_q[1] + sq_q[2] + ppcd_pkg::ONE_SQ;
      num_dly_q[0] <= num_q;
      for (int i = 1; i < SQRT_LAT; i++) begin
        num_dly_q[i] <= num_dly_q[i-1];
      end
      side_q[0] <= s3_q;
      for (int i = 1; i < SIDE_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  ppcd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad_q),
    .root_o (root)
  );

  assign gdiv = {root, {ppcd_pkg::FRAC_W{1'b0}}};

  for (genvar k = 0; k < NAX; k++) begin : g_step
    ppcd_div #(
      .NW (ppcd_pkg::STEP_NW),
      .DW (ppcd_pkg::GDIV_W),
      .QW (ppcd_pkg::DIST_W)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num_dly_q[SQRT_LAT-1][k]),
      .den_i (gdiv),
      .quo_o (dmag[k])
    );
  end

  // strict crossing: plane lies ahead of z and short of z + dz
  assign tail = side_q[SIDE_LAT-1];
  assign gap  = $signed({cfg_i.plane_position[ppcd_pkg::POS_W-1], cfg_i.plane_position})
              - $signed({tail.z_pos[ppcd_pkg::POS_W-1], tail.z_pos});
  assign hit_plane = vld_q[SIDE_LAT-1] && cfg_i.enable && !tail.mom_z[MW-1] && (gap > 0)
                  && ((ppcd_pkg::POS_W+1)'(dmag[2]) > $unsigned(gap));

  assign push_o = hit_plane && adv;

  always_comb begin
    cross_o.x_pos       = tail.x_pos;
    cross_o.y_pos       = tail.y_pos;
    cross_o.mom_x       = tail.mom_x;
    cross_o.mom_y       = tail.mom_y;
    cross_o.mom_z       = tail.mom_z;
    cross_o.particle_id = tail.particle_id;
    cross_o.now_fs      = tail.now_fs;
    cross_o.dx_mag      = dmag[0];
    cross_o.dy_mag      = dmag[1];
    cross_o.dz_mag      = dmag[2];
    cross_o.gap         = ppcd_pkg::DIST_W'($unsigned(gap));
  end

endmodule

>>> hw/rtl/ppcd_queue.sv
// Short word queue between front and back, flip-flop storage.
// Depends on ppcd_pkg.
`timescale 1ns / 1ps

module ppcd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ppcd_pkg::cross_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output ppcd_pkg::cross_t data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ppcd_pkg::cross_t mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/ppcd_back.sv
// Back end: interpolates x, y and time at the plane, saturates, drives results.
// Depends on ppcd_pkg and ppcd_div.
`timescale 1ns / 1ps

module ppcd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppcd_pkg::cfg_t    cfg_i,
  input  logic              q_valid_i,
  input  ppcd_pkg::cross_t  q_data_i,
  output logic              pop_o,
  output logic              res_valid_o,
  output ppcd_pkg::result_t res_o
);

  localparam int unsigned NAX     = 3;
  localparam int unsigned DIV_LAT = ppcd_pkg::DIST_W;
  localparam int unsigned PW      = ppcd_pkg::POS_W;
  localparam int unsigned NW      = ppcd_pkg::INTERP_NW;

  function automatic logic signed [PW-1:0] sat_pos(input logic signed [PW:0] v);
    if (v[PW] != v[PW-1]) begin
      return v[PW] ? $signed({1'b1, {(PW-1){1'b0}}}) : $signed({1'b0, {(PW-1){1'b1}}});
    end
    return v[PW-1:0];
  endfunction

  logic                          b1_vld_q, b2_vld_q;
  ppcd_pkg::cross_t              b1_q, b2_q;
  logic [NW-1:0]                 prod_q [NAX];
  logic [ppcd_pkg::DIST_W-1:0]   quo [NAX];
  ppcd_pkg::cross_t              side_q [DIV_LAT];
  logic [DIV_LAT-1:0]            vld_q;
  ppcd_pkg::cross_t              tail;
  logic signed [PW:0]            x_ext, y_ext, qx, qy, hx, hy;
  logic [ppcd_pkg::TIME_W:0]     t_sum;
  logic                          res_valid_q;
  ppcd_pkg::result_t             res_q;

  // the back end never stalls: drain the queue whenever it holds a word
  assign pop_o = q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q    <= 1'b0;
      b2_vld_q    <= 1'b0;
      vld_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      b1_vld_q    <= q_valid_i;
      b2_vld_q    <= b1_vld_q;
      vld_q       <= {vld_q[DIV_LAT-2:0], b2_vld_q};
      res_valid_q <= vld_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    b1_q      <= q_data_i;
    b2_q      <= b1_q;
    prod_q[0] <= NW'(b1_q.gap) * NW'(b1_q.dx_mag);
    prod_q[1] <= NW'(b1_q.gap) * NW'(b1_q.dy_mag);
    prod_q[2] <= NW'(b1_q.gap) * NW'(cfg_i.time_step_fs);
    side_q[0] <= b2_q;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  for (genvar k = 0; k < NAX; k++) begin : g_interp
    ppcd_div #(
      .NW (NW),
      .DW (ppcd_pkg::DIST_W),
      .QW (ppcd_pkg::DIST_W)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (1'b1),
      .num_i (prod_q[k]),
      .den_i (b2_q.dz_mag),
      .quo_o (quo[k])
    );
  end

  assign tail  = side_q[DIV_LAT-1];
  assign x_ext = $signed({tail.x_pos[PW-1], tail.x_pos});
  assign y_ext = $signed({tail.y_pos[PW-1], tail.y_pos});
  assign qx    = $signed((PW+1)'(quo[0]));
  assign qy    = $signed((PW+1)'(quo[1]));
  // step direction follows the sign of the momentum
  assign hx    = tail.mom_x[ppcd_pkg::MOM_W-1] ? x_ext - qx : x_ext + qx;
  assign hy    = tail.mom_y[ppcd_pkg::MOM_W-1] ? y_ext - qy : y_ext + qy;
  assign t_sum = {1'b0, tail.now_fs} + (ppcd_pkg::TIME_W+1)'(quo[2]);

  always_ff @(posedge clk_i) begin
    res_q.hit_x       <= sat_pos(hx);
    res_q.hit_y       <= sat_pos(hy);
    res_q.out_mom_x   <= tail.mom_x;
    res_q.out_mom_y   <= tail.mom_y;
    res_q.out_mom_z   <= tail.mom_z;
    res_q.out_id      <= tail.particle_id;
    res_q.hit_time_fs <= t_sum[ppcd_pkg::TIME_W] ? '1 : t_sum[ppcd_pkg::TIME_W-1:0];
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> hw/rtl/particle_plane_crossing_detector.sv
// Top level of the particle plane crossing detector.
// Depends on ppcd_pkg, ppcd_front, ppcd_queue and ppcd_back.
`timescale 1ns / 1ps

// How to use:
//   Input: drive one particle word on item_i with start high; it is taken at
//   a rising edge where busy is low. One word may be taken every clock.
//   Config: cfg_valid_i with cfg_index_i / cfg_data_i writes the plane
//   position (0), the time step in fs (1) or the enable bit (2). cfg_ready_o
//   is always high. Write only while no particle is in flight.
//   Output: a particle that strictly crosses the plane while enabled yields
//   one result word on res_o, marked by res_valid_o for a single cycle.
//   Others yield nothing. Results keep input order.
//   Path: each particle passes the 32-stage square root, then the two
//   chains of 36-stage dividers (step length, then interpolation).
//   Throughput: one particle per clock while busy is low; every stage is
//   fully pipelined.
//   The receiver cannot stall: the back end drains the queue every cycle, so
//   busy only rises if that queue fills.
//   Reset: registers return to plane 0, step 1000 fs, disabled; all
//   pipelines empty. No clearing pass is needed.
module particle_plane_crossing_detector #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  input  ppcd_pkg::item_t                    item_i,
  output logic                               busy,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ppcd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ppcd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                               res_valid_o,
  output ppcd_pkg::result_t                  res_o
);

  ppcd_pkg::cfg_t   cfg_q;
  logic             q_push, q_full, q_valid, q_pop;
  ppcd_pkg::cross_t q_wdata, q_rdata;

  // config registers are always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.plane_position <= '0;
      cfg_q.time_step_fs   <= ppcd_pkg::TSTEP_RESET;
      cfg_q.enable         <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ppcd_pkg::REG_PLANE:  cfg_q.plane_position <= $signed(cfg_data_i[ppcd_pkg::POS_W-1:0]);
        ppcd_pkg::REG_TSTEP:  cfg_q.time_step_fs   <= cfg_data_i[ppcd_pkg::TSTEP_W-1:0];
        ppcd_pkg::REG_ENABLE: cfg_q.enable         <= cfg_data_i[0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // front: gamma, step length, crossing test
  ppcd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .start_i (start),
    .item_i  (item_i),
    .full_i  (q_full),
    .busy_o  (busy),
    .push_o  (q_push),
    .cross_o (q_wdata)
  );

  // hold crossing words between the two halves
  ppcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // back: interpolation and result register
  ppcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .pop_o       (q_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // the front must freeze rather than push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("crossing word pushed into a full queue");

  // no result may appear while the monitor is offline
  a_result_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> cfg_q.enable)
    else $error("result strobe while disabled");

  // a word pushed in the same cycle as a pop must still be visible next cycle
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_push) |=> q_valid)
    else $error("queue lost a word pushed while popping");

endmodule

>>> tb/particle_plane_crossing_detector_test.sv
// Self-checking testbench for particle_plane_crossing_detector: drives particle words,
// predicts each plane crossing in 128-bit fixed point and checks every result word.
// Depends on ppcd_pkg and the detector RTL.
`timescale 1ns / 1ps

module particle_plane_crossing_detector_test;

  // unmapped register index; the block must ignore writes to it
  localparam logic [ppcd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint MAX_POS = 64'sd140737488355327;
  localparam longint MIN_POS = -64'sd140737488355328;
  localparam longint unsigned TIME_MAX = 64'hFFFF_FFFF_FFFF;
  // settle time after the last word, beyond the depth of the pipeline
  localparam int SETTLE_CYCLES = 130;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start;
  ppcd_pkg::item_t                 item_i;
  logic                            busy;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [ppcd_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [ppcd_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            res_valid_o;
  ppcd_pkg::result_t               res_o;

  particle_plane_crossing_detector i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .item_i      (item_i),
    .busy        (busy),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Shadow copy of the configuration registers, kept in step with each write.
  longint          plane_q;
  longint unsigned tstep_q;
  bit              enable_q;

  ppcd_pkg::result_t pending_hits[$];
  int                error_count;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Crossing predictor
  // ---------------------------------------------------------------------------

  // Floor square root, one bit at a time from the top.
  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  // Signed step length along one axis: c * dt * |p| / (gamma * 2^24), sign of p.
  function automatic longint axis_step(longint unsigned len, longint p,
                                       longint unsigned gdiv);
    logic [127:0]    num;
    logic [127:0]    quo;
    longint unsigned mag;
    mag = (p < 0) ? longint'(-p) : longint'(p);
    num = 128'(len) * 128'(mag);
    quo = num / 128'(gdiv);
    return (p < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  // Step vector of one particle under the current time step.
  function automatic void particle_step(input ppcd_pkg::item_t it, output longint dx,
                                        output longint dy, output longint dz);
    longint          px, py, pz;
    longint unsigned mx, my, mz, sq, gdiv, len;
    px = it.mom_x;
    py = it.mom_y;
    pz = it.mom_z;
    mx = (px < 0) ? -px : px;
    my = (py < 0) ? -py : py;
    mz = (pz < 0) ? -pz : pz;
    sq = mx * mx + my * my + mz * mz + (64'd1 << 48);
    gdiv = floor_sqrt(sq) << ppcd_pkg::FRAC_W;
    len = 64'(ppcd_pkg::C_Q24) * tstep_q;
    dx = axis_step(len, px, gdiv);
    dy = axis_step(len, py, gdiv);
    dz = axis_step(len, pz, gdiv);
  endfunction

  // Position at the plane: pos + sign(d) * gap * |d| / dz, clamped to 48 bits.
  function automatic longint position_at_plane(longint pos, longint unsigned gap,
                                               longint d, longint unsigned dz);
    logic [127:0] quo;
    longint       s;
    longint unsigned mag;
    mag = (d < 0) ? -d : d;
    quo = (128'(gap) * 128'(mag)) / 128'(dz);
    s = (d < 0) ? pos - longint'(quo[63:0]) : pos + longint'(quo[63:0]);
    if (s > MAX_POS) s = MAX_POS;
    if (s < MIN_POS) s = MIN_POS;
    return s;
  endfunction

  // Returns 1 and the expected word when the particle strictly crosses the plane.
  function automatic bit predict_crossing(input ppcd_pkg::item_t it,
                                          output ppcd_pkg::result_t hit);
    longint          z, dx, dy, dz;
    longint unsigned gap, t;
    logic [127:0]    frac_t;
    hit = '0;
    if (!enable_q) return 0;
    particle_step(it, dx, dy, dz);
    z = it.z_pos;
    if (!(z < plane_q && z + dz > plane_q)) return 0;
    gap = plane_q - z;
    frac_t = (128'(gap) * 128'(tstep_q)) / 128'(dz);
    t = it.now_fs + frac_t[63:0];
    if (t > TIME_MAX) t = TIME_MAX;
    hit.hit_x       = ppcd_pkg::POS_W'(position_at_plane(it.x_pos, gap, dx, dz));
    hit.hit_y       = ppcd_pkg::POS_W'(position_at_plane(it.y_pos, gap, dy, dz));
    hit.out_mom_x   = it.mom_x;
    hit.out_mom_y   = it.mom_y;
    hit.out_mom_z   = it.mom_z;
    hit.out_id      = it.particle_id;
    hit.hit_time_fs = ppcd_pkg::TIME_W'(t);
    return 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one particle word after a random idle gap; predict at the accepting edge.
  task automatic send_particle(input ppcd_pkg::item_t it);
    int                idle;
    ppcd_pkg::result_t hit;
    idle = $urandom_range(0, 9);
    // Keep some back-to-back bursts with no idling at all.
    if ($urandom_range(0, 3) == 0) idle = 0;
    if (idle > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (idle - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    // Hold the word until an edge sees busy low.
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    if (predict_crossing(it, hit)) pending_hits.push_back(hit);
  endtask

  // Drop start, wait for every expected hit, then let the pipeline run dry
  // since particles that miss the plane leave no trace at the output.
  task automatic drain_pipeline();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; the block must be idle.
  task automatic write_register(input logic [ppcd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ppcd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    case (idx)
      ppcd_pkg::REG_PLANE: begin
        plane_q = longint'(signed'(data));
      end
      ppcd_pkg::REG_TSTEP: begin
        tstep_q = 64'(data[ppcd_pkg::TSTEP_W-1:0]);
      end
      ppcd_pkg::REG_ENABLE: begin
        enable_q = data[0];
      end
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input longint plane, input longint unsigned tstep,
                            input bit en);
    drain_pipeline();
    write_register(ppcd_pkg::REG_PLANE, ppcd_pkg::CFG_DATA_W'(plane));
    write_register(ppcd_pkg::REG_TSTEP, ppcd_pkg::CFG_DATA_W'(tstep));
    write_register(ppcd_pkg::REG_ENABLE, ppcd_pkg::CFG_DATA_W'(en));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic longint unsigned rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic ppcd_pkg::item_t noise_particle();
    ppcd_pkg::item_t it;
    it.x_pos       = ppcd_pkg::POS_W'(rand64());
    it.y_pos       = ppcd_pkg::POS_W'(rand64());
    it.z_pos       = ppcd_pkg::POS_W'(rand64());
    it.mom_x       = $urandom;
    it.mom_y       = $urandom;
    it.mom_z       = $urandom;
    it.particle_id = $urandom;
    it.now_fs      = ppcd_pkg::TIME_W'(rand64());
    return it;
  endfunction

  // A particle placed just upstream of the plane, moving forward, so that
  // most of them cross within one step; content is otherwise random.
  function automatic ppcd_pkg::item_t aimed_particle();
    ppcd_pkg::item_t it;
    longint unsigned reach, gap;
    longint          z;
    it = noise_particle();
    case ($urandom_range(0, 3))
      0: it.mom_z = $urandom_range(1, 32'h00FF_FFFF);
      1: it.mom_z = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
      default: it.mom_z = $urandom_range(32'h0040_0000, 32'h0800_0000);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      it.mom_x = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      it.mom_y = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    end
    // rough step length at beta = 1
    reach = (64'(ppcd_pkg::C_Q24) * tstep_q) >> ppcd_pkg::FRAC_W;
    if (reach == 0) reach = 1;
    gap = (rand64() % reach) + 1;
    z = plane_q - longint'(gap);
    if (z < MIN_POS) z = MIN_POS;
    it.z_pos = ppcd_pkg::POS_W'(z);
    if ($urandom_range(0, 7) == 0)
      it.x_pos = ppcd_pkg::POS_W'(MAX_POS - $urandom_range(0, 1000));
    if ($urandom_range(0, 7) == 0)
      it.y_pos = ppcd_pkg::POS_W'(MIN_POS + $urandom_range(0, 1000));
    if ($urandom_range(0, 7) == 0)
      it.now_fs = ppcd_pkg::TIME_W'(TIME_MAX - $urandom_range(0, 5000));
    return it;
  endfunction

  task automatic send_random_stream(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) send_particle(noise_particle());
      else send_particle(aimed_particle());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // After reset the monitor is offline: nothing may come out.
  task automatic test_disabled_after_reset();
    for (int n = 0; n < 10; n++) send_particle(aimed_particle());
  endtask

  task automatic test_directed_cases();
    ppcd_pkg::item_t it;
    longint          dx, dy, dz;
    set_config(0, 1000, 1'b1);
    // plain forward crossing at beta of about 0.71
    it = '0;
    it.mom_z = 32'sh0100_0000;
    it.z_pos = -48'sd100;
    it.particle_id = 32'hFFFF_FFFF;
    send_particle(it);
    // start exactly on the plane: no crossing
    it.z_pos = '0;
    send_particle(it);
    // land exactly on the plane: no crossing
    particle_step(it, dx, dy, dz);
    it.z_pos = ppcd_pkg::POS_W'(-dz);
    send_particle(it);
    it.z_pos = ppcd_pkg::POS_W'(-dz + 1);
    send_particle(it);
    // backward motion never crosses
    it.mom_z = 32'sh8000_0000;
    it.z_pos = 48'sd5;
    send_particle(it);
    // extreme momenta, both transverse signs
    it.mom_z = 32'sh7FFF_FFFF;
    it.mom_x = 32'sh8000_0000;
    it.mom_y = 32'sh7FFF_FFFF;
    it.z_pos = -48'sd1;
    send_particle(it);
    // saturate the interpolated positions
    it.mom_x = 32'sh7FFF_FFFF;
    it.mom_y = 32'sh8000_0000;
    it.mom_z = 32'sh0000_4000;
    it.x_pos = ppcd_pkg::POS_W'(MAX_POS);
    it.y_pos = ppcd_pkg::POS_W'(MIN_POS);
    particle_step(it, dx, dy, dz);
    it.z_pos = ppcd_pkg::POS_W'((dz > 1) ? -(dz - 1) : -1);
    send_particle(it);
    // saturate the crossing time
    it.now_fs = ppcd_pkg::TIME_W'(TIME_MAX);
    send_particle(it);
    it.now_fs = '0;
    it.x_pos = ppcd_pkg::POS_W'(MIN_POS);
    it.y_pos = ppcd_pkg::POS_W'(MAX_POS);
    send_particle(it);
    // slowest forward particle
    it = '0;
    it.mom_z = 32'sd1;
    it.z_pos = -48'sd1;
    send_particle(it);
    // longest step and far plane
    set_config(MAX_POS, 32'hFFFF_FFFF, 1'b1);
    it = '0;
    it.mom_z = 32'sh7FFF_FFFF;
    it.z_pos = ppcd_pkg::POS_W'(MAX_POS - 64'sd1000000);
    send_particle(it);
    it.z_pos = ppcd_pkg::POS_W'(MIN_POS);
    send_particle(it);
    it.z_pos = ppcd_pkg::POS_W'(MAX_POS);
    send_particle(it);
    // zero time step: nothing moves, nothing crosses
    set_config(0, 0, 1'b1);
    it = '0;
    it.mom_z = 32'sh7FFF_FFFF;
    it.z_pos = -48'sd1;
    send_particle(it);
    // an unmapped register index changes nothing
    drain_pipeline();
    write_register(REG_UNUSED, '1);
    send_particle(it);
  endtask

  task automatic test_random_settings();
    set_config(0, 1000, 1'b1);
    send_random_stream(200);
    // the sender holds off here until every crossing has come back
    set_config(MAX_POS, 32'hFFFF_FFFF, 1'b1);
    send_random_stream(150);
    set_config(MIN_POS + 64'sd4000000000, 1, 1'b1);
    send_random_stream(150);
    set_config(longint'(signed'(48'(rand64()))), $urandom_range(1, 100000), 1'b1);
    send_random_stream(200);
    set_config(longint'(signed'(48'(rand64()))), $urandom, 1'b1);
    send_random_stream(200);
    // offline again: every particle is dropped
    set_config(longint'(signed'(48'(rand64()))), $urandom_range(1, 5000), 1'b0);
    send_random_stream(80);
    set_config(-64'sd123456789, 1000, 1'b1);
    send_random_stream(150);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    ppcd_pkg::result_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected result word, out_id", res_o.out_id, '0);
      end else begin
        want = pending_hits[0];
        pending_hits.delete(0);
        if (res_o.hit_x !== want.hit_x)
          report_mismatch("hit_x", res_o.hit_x, want.hit_x);
        if (res_o.hit_y !== want.hit_y)
          report_mismatch("hit_y", res_o.hit_y, want.hit_y);
        if (res_o.out_mom_x !== want.out_mom_x)
          report_mismatch("out_mom_x", res_o.out_mom_x, want.out_mom_x);
        if (res_o.out_mom_y !== want.out_mom_y)
          report_mismatch("out_mom_y", res_o.out_mom_y, want.out_mom_y);
        if (res_o.out_mom_z !== want.out_mom_z)
          report_mismatch("out_mom_z", res_o.out_mom_z, want.out_mom_z);
        if (res_o.out_id !== want.out_id)
          report_mismatch("out_id", res_o.out_id, want.out_id);
        if (res_o.hit_time_fs !== want.hit_time_fs)
          report_mismatch("hit_time_fs", res_o.hit_time_fs, want.hit_time_fs);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    error_count = 0;
    plane_q     = 0;
    tstep_q     = 64'(ppcd_pkg::TSTEP_RESET);
    enable_q    = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = ppcd_pkg::REG_PLANE;
    cfg_data_i  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_disabled_after_reset();
    test_directed_cases();
    test_random_settings();
    drain_pipeline();

    if (error_count == 0 && pending_hits.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
